### src/json_string_escaper_macros.svh
// Assertion macros of the checking file of the JSON string escaper.
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH

// Same-cycle implication, reset masked.
`define JSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masked.
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Types, character codes and helpers of the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

	// Escape classes
	localparam logic [1:0] KIND_PLAIN = 2'd0; // copied byte
	localparam logic [1:0] KIND_SHORT = 2'd1; // backslash plus one char
	localparam logic [1:0] KIND_U1    = 2'd2; // one \uXXXX
	localparam logic [1:0] KIND_U2    = 2'd3; // surrogate pair, two \uXXXX

	localparam logic [6:0] CH_QUOTE  = 7'h22;
	localparam logic [6:0] CH_BSLASH = 7'h5C;
	localparam logic [6:0] CH_U      = 7'h75;
	localparam logic [6:0] CH_T      = 7'h74;
	localparam logic [6:0] CH_N      = 7'h6E;
	localparam logic [6:0] CH_R      = 7'h72;
	localparam logic [6:0] CH_F      = 7'h66;
	localparam logic [6:0] CH_B      = 7'h62;

	localparam logic [20:0] SUPP_BASE = 21'h10000;
	localparam logic [5:0]  HI_SURR   = 6'b110110; // 0xD800 >> 10
	localparam logic [5:0]  LO_SURR   = 6'b110111; // 0xDC00 >> 10
	localparam logic [3:0]  U_LEN     = 4'd6;

	typedef struct packed {
		logic [20:0] code_point;
		logic        string_start;
		logic        string_end;
		logic        string_empty;
	} char_item_t;

	typedef struct packed {
		logic [6:0] out_byte;
		logic       last_byte;
	} byte_item_t;

	// Classified item as queued between front and back
	typedef struct packed {
		logic        empty;
		logic        start;
		logic [1:0]  kind;
		logic [6:0]  ch;
		logic [15:0] hi;
		logic [15:0] lo;
		logic [3:0]  len;
	} desc_t;

	typedef struct packed {
		logic  valid;
		desc_t desc;
	} q_head_t;

	function automatic logic [6:0] hex_digit(input logic [3:0] nib);
		logic [6:0] r;
		if (nib < 4'd10) begin
			r = 7'h30 + {3'b000, nib};
		end else begin
			r = 7'h57 + {3'b000, nib};
		end
		return r;
	endfunction

	function automatic logic [3:0] body_len(input logic [1:0] kind);
		logic [3:0] r;
		case (kind)
			KIND_PLAIN: r = 4'd1;
			KIND_SHORT: r = 4'd2;
			KIND_U1:    r = U_LEN;
			KIND_U2:    r = 4'd12;
			default:    r = 4'd1;
		endcase
		return r;
	endfunction

endpackage

### src/jse_stream_if.sv
// ----------------------------------------------------------------------------
// jse_char_if / jse_byte_if
// Valid/ready channels for code points in and escaped bytes out.
// ----------------------------------------------------------------------------
interface jse_char_if;
	import jse_pkg::*;
	logic       valid;
	logic       ready;
	char_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface jse_byte_if;
	import jse_pkg::*;
	logic       valid;
	logic       ready;
	byte_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Accepts code points and classifies each into an escape descriptor.
// ----------------------------------------------------------------------------
module jse_front (
	jse_char_if.sink      code,
	input  logic          full,
	output logic          push,
	output jse_pkg::desc_t desc
);
	import jse_pkg::*;

	logic [20:0] cp;
	logic [19:0] off;
	logic        is_qb;
	logic        is_short;
	logic [6:0]  short_ch;
	logic        is_ctrl;
	logic [1:0]  kind;
	logic [3:0]  flags;

	assign cp  = code.data.code_point;
	// only the low 20 bits of the offset feed the surrogate halves
	assign off = cp[19:0] - SUPP_BASE[19:0];

	assign is_qb   = (cp == {14'd0, CH_QUOTE}) || (cp == {14'd0, CH_BSLASH});
	assign is_ctrl = (cp < 21'h20) || (cp >= 21'h7F);

	always_comb begin
		is_short = 1'b1;
		short_ch = CH_T;
		case (cp)
			21'h09:  short_ch = CH_T;
			21'h0A:  short_ch = CH_N;
			21'h0D:  short_ch = CH_R;
			21'h0C:  short_ch = CH_F;
			21'h08:  short_ch = CH_B;
			default: is_short = 1'b0;
		endcase
	end

	always_comb begin
		if (is_qb) begin
			kind = KIND_SHORT;
		end else if (cp >= SUPP_BASE) begin
			kind = KIND_U2;
		end else if (cp >= 21'd256) begin
			kind = KIND_U1;
		end else if (is_short) begin
			kind = KIND_SHORT;
		end else if (is_ctrl) begin
			kind = KIND_U1;
		end else begin
			kind = KIND_PLAIN;
		end
	end

	assign flags = {3'b000, code.data.string_start} + {3'b000, code.data.string_end};

	always_comb begin
		desc.empty = code.data.string_empty;
		desc.start = code.data.string_start;
		desc.kind  = kind;
		desc.ch    = is_short && !is_qb ? short_ch : cp[6:0];
		if (kind == KIND_U2) begin
			desc.hi = {HI_SURR, off[19:10]};
			desc.lo = {LO_SURR, off[9:0]};
		end else begin
			desc.hi = cp[15:0];
			desc.lo = cp[15:0];
		end
		desc.len = code.data.string_empty ? 4'd2 : flags + body_len(kind);
	end

	assign code.ready = !full;
	assign push       = code.valid && !full;

endmodule

### src/jse_queue.sv
// ----------------------------------------------------------------------------
// jse_queue
// Two-entry descriptor queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module jse_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jse_pkg::desc_t  desc,
	output logic            full,
	input  logic            pop,
	output jse_pkg::q_head_t head
);
	import jse_pkg::*;

	desc_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head.valid = (cnt_q != 2'd0);
	assign head.desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### src/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Walks the head descriptor one byte per cycle, while text.ready does not stall it, into the output register.
// ----------------------------------------------------------------------------
module jse_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jse_pkg::q_head_t head,
	output logic             pop,
	jse_byte_if.source       text
);
	import jse_pkg::*;

	logic [3:0]  idx_q;
	logic        out_v_q;
	byte_item_t  out_q;

	desc_t       d;
	logic [3:0]  b;
	logic [3:0]  blen;
	logic        second;
	logic [2:0]  j;
	logic [15:0] val;
	logic [6:0]  body_byte;
	logic [6:0]  cur_byte;
	logic        last;
	logic        advance;

	assign d      = head.desc;
	assign b      = idx_q - {3'b000, d.start};
	assign blen   = body_len(d.kind);
	assign second = (d.kind == KIND_U2) && (b >= U_LEN);
	assign j      = second ? 3'(b - U_LEN) : b[2:0];
	assign val    = second ? d.lo : d.hi;

	always_comb begin
		case (d.kind)
			KIND_PLAIN: body_byte = d.ch;
			KIND_SHORT: body_byte = (b == 4'd0) ? CH_BSLASH : d.ch;
			default: begin
				case (j)
					3'd0:    body_byte = CH_BSLASH;
					3'd1:    body_byte = CH_U;
					3'd2:    body_byte = hex_digit(val[15:12]);
					3'd3:    body_byte = hex_digit(val[11:8]);
					3'd4:    body_byte = hex_digit(val[7:4]);
					3'd5:    body_byte = hex_digit(val[3:0]);
					default: body_byte = CH_BSLASH;
				endcase
			end
		endcase
	end

	always_comb begin
		if (d.empty) begin
			cur_byte = CH_QUOTE;
		end else if (d.start && idx_q == 4'd0) begin
			cur_byte = CH_QUOTE;
		end else if (b >= blen) begin
			cur_byte = CH_QUOTE;
		end else begin
			cur_byte = body_byte;
		end
	end

	assign last    = (idx_q == d.len - 4'd1);
	assign advance = !out_v_q || text.ready;
	assign pop     = advance && head.valid && last;

	always_ff @(posedge clk) begin
		if (advance && head.valid) begin
			out_q.out_byte  <= cur_byte;
			out_q.last_byte <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 4'd0;
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= head.valid;
			if (head.valid) begin
				// restart the byte walk on the next item
				idx_q <= last ? 4'd0 : idx_q + 4'd1;
			end
		end
	end

	assign text.valid = out_v_q;
	assign text.data  = out_q;

endmodule

### src/json_string_escaper.sv
// A code point accepted into the queue is walked from the queue head into the output register.
// Throughput: one output byte per cycle while text.ready does not stall the output; an item
// has 1 byte for a copied char up to 14 bytes for a quoted surrogate pair.
// A two-entry queue decouples classification from byte output.
// Reset (arst_n low) empties the queue and the output register at once.
// ----------------------------------------------------------------------------
// json_string_escaper
// Escapes one Unicode code point per transaction into JSON ASCII bytes.
// ----------------------------------------------------------------------------
module json_string_escaper (
	input logic      clk,
	input logic      arst_n,
	jse_char_if.sink   code,
	jse_byte_if.source text
);
	import jse_pkg::*;

	logic    push;
	logic    full;
	logic    pop;
	desc_t   desc;
	q_head_t head;

	jse_front u_front (
		.code (code),
		.full (full),
		.push (push),
		.desc (desc)
	);

	jse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.desc   (desc),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	jse_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.text   (text)
	);

endmodule

### src/jse_checker.sv
// ----------------------------------------------------------------------------
// jse_checker
// Port-level checks of the JSON string escaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_string_escaper_macros.svh"

module jse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       code_valid,
	input logic       code_ready,
	input logic       text_valid,
	input logic       text_ready,
	input logic [6:0] text_out_byte,
	input logic       text_last_byte
);

	logic [2:0] pend_q;

	// track items accepted whose final byte is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'b00, code_valid && code_ready}
				- {2'b00, text_valid && text_ready && text_last_byte};
		end
	end

	`JSE_ASSERT_NEXT(a_stall_hold, text_valid && !text_ready,
		text_valid && $stable(text_out_byte) && $stable(text_last_byte),
		"output changed while stalled")

	`JSE_ASSERT_NOW(a_printable, text_valid,
		text_out_byte >= 7'h20 && text_out_byte != 7'h7F,
		"non-printable output byte")

	`JSE_ASSERT_NOW(a_no_invented, text_valid, pend_q != 3'd0,
		"output byte without a pending item")

endmodule

bind json_string_escaper jse_checker u_jse_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.code_valid     (code.valid),
	.code_ready     (code.ready),
	.text_valid     (text.valid),
	.text_ready     (text.ready),
	.text_out_byte  (text.data.out_byte),
	.text_last_byte (text.data.last_byte)
);

### tb/json_string_escaper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_escaper_tb
// Feeds code points with string framing flags into the escaper and checks
// every escaped output byte, and its last-byte flag, against an in-bench
// escape predictor. Covers directed corner cases, framed strings, a full-rate
// stretch and random framing noise, with random stalls on both channels.
// ----------------------------------------------------------------------------
module json_string_escaper_tb;
	import jse_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 30;
	localparam int MAX_REPORTS  = 40;
	localparam int IDLE_PCT     = 8;

	localparam logic [20:0] CP_LAST_UNICODE = 21'h10FFFF;
	localparam logic [20:0] CP_MAX          = 21'h1FFFFF;

	localparam logic [7:0] HEX_DIGITS [16] = '{"0", "1", "2", "3", "4", "5", "6", "7",
		"8", "9", "a", "b", "c", "d", "e", "f"};

	logic clk;
	logic arst_n;

	jse_char_if code_ch ();
	jse_byte_if text_ch ();

	json_string_escaper i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (code_ch),
		.text   (text_ch)
	);

	byte_item_t pending_bytes[$];
	logic [6:0] escape_seq[$];
	int         error_count;
	int         items_sent;
	int         cycle_count;
	logic       full_rate;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("json_string_escaper_tb: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Escape predictor
	// ------------------------------------------------------------------
	function automatic void put_u16(input logic [15:0] v);
		escape_seq.push_back(CH_BSLASH);
		escape_seq.push_back(CH_U);
		escape_seq.push_back(HEX_DIGITS[v[15:12]][6:0]);
		escape_seq.push_back(HEX_DIGITS[v[11:8]][6:0]);
		escape_seq.push_back(HEX_DIGITS[v[7:4]][6:0]);
		escape_seq.push_back(HEX_DIGITS[v[3:0]][6:0]);
	endfunction

	function automatic void put_short(input logic [6:0] ch);
		escape_seq.push_back(CH_BSLASH);
		escape_seq.push_back(ch);
	endfunction

	function automatic void escape_code_point(input char_item_t it);
		logic [20:0] cp;
		logic [20:0] offset;
		byte_item_t  b;
		cp = it.code_point;
		escape_seq.delete();
		if (it.string_empty) begin
			escape_seq.push_back(CH_QUOTE);
			escape_seq.push_back(CH_QUOTE);
		end else begin
			if (it.string_start) begin
				escape_seq.push_back(CH_QUOTE);
			end
			if (cp == {14'd0, CH_QUOTE} || cp == {14'd0, CH_BSLASH}) begin
				put_short(cp[6:0]);
			end else if (cp >= SUPP_BASE) begin
				// high half wraps for code points past the Unicode range
				offset = cp - SUPP_BASE;
				put_u16(16'hD800 + {6'd0, offset[19:10]});
				put_u16(16'hDC00 + {6'd0, offset[9:0]});
			end else if (cp >= 21'd256) begin
				put_u16(cp[15:0]);
			end else begin
				case (cp[7:0])
					8'h09: put_short(CH_T);
					8'h0A: put_short(CH_N);
					8'h0D: put_short(CH_R);
					8'h0C: put_short(CH_F);
					8'h08: put_short(CH_B);
					default: begin
						if (cp < 21'h20 || cp >= 21'h7F) begin
							put_u16(cp[15:0]);
						end else begin
							escape_seq.push_back(cp[6:0]);
						end
					end
				endcase
			end
			if (it.string_end) begin
				escape_seq.push_back(CH_QUOTE);
			end
		end
		foreach (escape_seq[k]) begin
			b.out_byte  = escape_seq[k];
			b.last_byte = (k == escape_seq.size() - 1);
			pending_bytes.push_back(b);
		end
	endfunction

	// ------------------------------------------------------------------
	// Output side: random back-pressure and byte checking
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		text_ch.ready <= full_rate || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	task automatic report_mismatch(input string what, input logic [6:0] want,
			input logic [6:0] got);
		if (error_count < MAX_REPORTS) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
		error_count++;
	endtask

	always @(posedge clk) begin : check_bytes
		byte_item_t want;
		if (arst_n && text_ch.valid && text_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				if (error_count < MAX_REPORTS) begin
					$display("%0t: unexpected byte, expected none, actual %h last %b",
						$time, text_ch.data.out_byte, text_ch.data.last_byte);
				end
				error_count++;
			end else begin
				want = pending_bytes.pop_front();
				if (text_ch.data.out_byte !== want.out_byte) begin
					report_mismatch("out_byte", want.out_byte, text_ch.data.out_byte);
				end
				if (text_ch.data.last_byte !== want.last_byte) begin
					report_mismatch("last_byte", {6'd0, want.last_byte},
						{6'd0, text_ch.data.last_byte});
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	task automatic send_char(input char_item_t it);
		if (!full_rate && $urandom_range(0, 99) < IDLE_PCT) begin
			code_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		code_ch.valid <= 1'b1;
		code_ch.data  <= it;
		do @(posedge clk); while (!code_ch.ready);
		escape_code_point(it);
		items_sent++;
	endtask

	task automatic send_fields(input logic [20:0] cp, input logic s, input logic e,
			input logic m);
		char_item_t it;
		it.code_point   = cp;
		it.string_start = s;
		it.string_end   = e;
		it.string_empty = m;
		send_char(it);
	endtask

	function automatic logic [20:0] rand_code_point();
		logic [20:0] r;
		case ($urandom_range(0, 11))
			0, 1, 2, 3: r = 21'($urandom_range(21'h20, 21'h7E));
			4:          r = 21'($urandom_range(21'h00, 21'h1F));
			5:          r = $urandom_range(0, 1) ? {14'd0, CH_QUOTE} : {14'd0, CH_BSLASH};
			6:          r = 21'($urandom_range(21'h7F, 21'hFF));
			7:          r = 21'($urandom_range(21'h100, 21'hFFFF));
			8:          r = 21'($urandom_range(21'hD800, 21'hDFFF));
			9:          r = 21'($urandom_range(21'h10000, CP_LAST_UNICODE));
			10:         r = 21'($urandom_range(21'h110000, CP_MAX));
			default:    r = 21'($urandom() & CP_MAX);
		endcase
		return r;
	endfunction

	// a zero length makes an empty-string transaction with random ignored fields
	task automatic send_string(input int len);
		if (len == 0) begin
			send_fields(21'($urandom() & CP_MAX), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'b1);
		end else begin
			for (int i = 0; i < len; i++) begin
				send_fields(rand_code_point(), i == 0, i == len - 1, 1'b0);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		logic [20:0] corners [20];
		corners = '{21'h00, 21'h08, 21'h09, 21'h0A, 21'h0C, 21'h0D, 21'h1F, 21'h20,
			21'h22, 21'h5C, 21'h41, 21'h7E, 21'h7F, 21'hFF, 21'h100, 21'hD800,
			21'hDFFF, 21'hFFFF, 21'h10000, CP_LAST_UNICODE};
		foreach (corners[i]) begin
			send_fields(corners[i], i == 0, i == 19, 1'b0);
		end
		// widest item: quoted surrogate pair on both sides
		send_fields(CP_LAST_UNICODE, 1'b1, 1'b1, 1'b0);
		send_fields(CP_MAX, 1'b1, 1'b1, 1'b0);
		send_fields(21'h110000, 1'b0, 1'b0, 1'b0);
		send_fields(CP_MAX, 1'b1, 1'b1, 1'b1);
		send_fields(21'h0, 1'b0, 1'b0, 1'b1);
	endtask

	task automatic test_strings(input int n_items);
		int target;
		target = items_sent + n_items;
		while (items_sent < target) begin
			send_string($urandom_range(0, 10));
		end
	endtask

	task automatic test_full_rate(input int n_items);
		full_rate = 1'b1;
		test_strings(n_items);
		full_rate = 1'b0;
	endtask

	task automatic test_noise(input int n_items);
		repeat (n_items) begin
			send_fields(rand_code_point(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		full_rate     = 1'b0;
		error_count   = 0;
		items_sent    = 0;
		cycle_count   = 0;
		code_ch.valid = 1'b0;
		code_ch.data  = '0;
		text_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_strings(250);
		test_full_rate(60);
		test_noise(80);

		code_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("json_string_escaper_tb: done, clean");
		end else begin
			$display("json_string_escaper_tb: done, errors");
		end
		$finish;
	end

endmodule
